// ===== rtl/wsp_pkg.sv =====
// Shared types and constants of the weighted stratum picker.
package wsp_pkg;

   localparam int unsigned NUM_STRATA_DEF   = 32;
   localparam int unsigned WEIGHT_WIDTH_DEF = 32;

   localparam int unsigned MODE_W    = 2;
   localparam int unsigned STRATUM_W = 5;
   localparam int unsigned WEIGHT_W  = 32;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned PICK_W    = 5;
   localparam int unsigned MCNT_W    = $clog2(FRAC_W);

   typedef enum logic [MODE_W-1:0] {
      MODE_SET    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_DRAW   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_MUL,
      ST_CLEAR,
      ST_SEL,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      DP_HOLD,
      DP_START,
      DP_ACC,
      DP_MUL,
      DP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      add_en;
   } dp_ctrl_type;

   typedef struct packed {
      logic zero;
      logic hit;
   } dp_stat_type;

endpackage

// ===== rtl/wsp_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface wsp_req_if;
   logic                           valid;
   logic                           ready;
   logic [wsp_pkg::MODE_W-1:0]     mode;
   logic [wsp_pkg::STRATUM_W-1:0]  stratum;
   logic [wsp_pkg::WEIGHT_W-1:0]   weight;
   logic [wsp_pkg::FRAC_W-1:0]     random;

   modport source (output valid, mode, stratum, weight, random, input ready);
   modport sink (input valid, mode, stratum, weight, random, output ready);
endinterface

interface wsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wsp_pkg::PICK_W-1:0]  picked;
   logic                        empty_res;

   modport source (output valid, picked, empty_res, input ready);
   modport sink (input valid, picked, empty_res, output ready);
endinterface

// ===== rtl/weighted_stratum_picker_top.sv =====
// Roulette-wheel stratum picker: a table of weights with present bits, drawn
// in proportion to weight. Set and remove items complete in the cycle they are
// taken and give no response. A draw item makes one pass over the weight
// memory to sum the present weights, takes 16 shift-add steps on the shared
// adder to form threshold = (sum*random)>>16, and makes a second memory pass
// that stops at the first present entry whose running sum exceeds the
// threshold. The single read port of the weight memory and the one shared
// adder set the length of a draw. The request side is not ready while a draw
// is in progress or its response is waiting. Reset clears all present bits at
// once; no clearing pass is needed.
module weighted_stratum_picker_top #(
   parameter int unsigned NUM_STRATA   = wsp_pkg::NUM_STRATA_DEF,
   parameter int unsigned WEIGHT_WIDTH = wsp_pkg::WEIGHT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wsp_req_if.sink   req_ch,
   wsp_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W = (NUM_STRATA > 1) ? $clog2(NUM_STRATA) : 1;
   localparam int unsigned CNT_W = $clog2(NUM_STRATA + 1);
   localparam int unsigned SUM_W = WEIGHT_WIDTH + CNT_W;

   wsp_pkg::state_type        state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic [wsp_pkg::MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   logic                      empty_ff, empty_in;
   logic [NUM_STRATA-1:0]     present_ff, present_in;

   wsp_pkg::dp_ctrl_type      dp_ctrl;
   wsp_pkg::dp_stat_type      dp_stat;
   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [WEIGHT_WIDTH-1:0]   ram_wdata;
   logic [IDX_W-1:0]          ram_raddr;
   logic [WEIGHT_WIDTH-1:0]   ram_rdata;

   logic                      req_fire;
   logic                      in_range;
   logic                      issue;
   logic [IDX_W+wsp_pkg::STRATUM_W-1:0] stratum_ext;
   logic [WEIGHT_WIDTH+wsp_pkg::WEIGHT_W-1:0] weight_ext;
   logic [IDX_W+wsp_pkg::PICK_W-1:0] pick_ext;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign stratum_ext = {{IDX_W{1'b0}}, req_ch.stratum};
   assign weight_ext  = {{WEIGHT_WIDTH{1'b0}}, req_ch.weight};
   assign in_range    = ({{(32 - wsp_pkg::STRATUM_W){1'b0}}, req_ch.stratum} < 32'(NUM_STRATA));
   assign ram_waddr   = stratum_ext[IDX_W-1:0];
   assign issue       = (cnt_ff < CNT_W'(NUM_STRATA));
   assign ram_raddr   = issue ? cnt_ff[IDX_W-1:0] : '0;

   wsp_ram #(
      .DEPTH  (NUM_STRATA),
      .ADDR_W (IDX_W),
      .DATA_W (WEIGHT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wsp_datapath #(
      .WEIGHT_WIDTH (WEIGHT_WIDTH),
      .SUM_W        (SUM_W)
   ) u_datapath (
      .clock     (clock),
      .ctrl      (dp_ctrl),
      .rd_data   (ram_rdata),
      .frac_load (req_ch.random),
      .stat      (dp_stat)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      mcnt_in     = mcnt_ff;
      pick_in     = pick_ff;
      empty_in    = empty_ff;
      present_in  = present_ff;
      dp_ctrl     = '{op: wsp_pkg::DP_HOLD, add_en: 1'b0};
      ram_we      = 1'b0;
      ram_wdata   = weight_ext[WEIGHT_WIDTH-1:0];

      unique case (state_ff)
         wsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.mode)
                  wsp_pkg::MODE_SET: begin
                     if (in_range) begin
                        ram_we                = 1'b1;
                        present_in[ram_waddr] = 1'b1;
                     end
                  end
                  wsp_pkg::MODE_REMOVE: begin
                     if (in_range) begin
                        ram_we                = 1'b1;
                        ram_wdata             = '0;
                        present_in[ram_waddr] = 1'b0;
                     end
                  end
                  wsp_pkg::MODE_DRAW: begin
                     dp_ctrl.op = wsp_pkg::DP_START;
                     cnt_in     = '0;
                     pend_in    = 1'b0;
                     state_in   = wsp_pkg::ST_SUM;
                  end
                  default: begin
                     // unused mode: drop the item
                  end
               endcase
            end
         end
         wsp_pkg::ST_SUM: begin
            pend_in     = issue;
            pend_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               dp_ctrl.op     = wsp_pkg::DP_ACC;
               dp_ctrl.add_en = present_ff[pend_idx_ff];
            end
            if (!issue && !pend_ff) begin
               state_in = wsp_pkg::ST_CHECK;
            end
         end
         wsp_pkg::ST_CHECK: begin
            pick_in = '0;
            mcnt_in = '0;
            if (dp_stat.zero) begin
               empty_in = 1'b1;
               state_in = wsp_pkg::ST_RESP;
            end else begin
               empty_in = 1'b0;
               state_in = wsp_pkg::ST_MUL;
            end
         end
         wsp_pkg::ST_MUL: begin
            dp_ctrl.op = wsp_pkg::DP_MUL;
            mcnt_in    = mcnt_ff + wsp_pkg::MCNT_W'(1);
            if (mcnt_ff == wsp_pkg::MCNT_W'(wsp_pkg::FRAC_W - 1)) begin
               state_in = wsp_pkg::ST_CLEAR;
            end
         end
         wsp_pkg::ST_CLEAR: begin
            dp_ctrl.op = wsp_pkg::DP_CLEAR;
            cnt_in     = '0;
            pend_in    = 1'b0;
            state_in   = wsp_pkg::ST_SEL;
         end
         wsp_pkg::ST_SEL: begin
            pend_in     = issue;
            pend_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff && present_ff[pend_idx_ff]) begin
               dp_ctrl.op     = wsp_pkg::DP_ACC;
               dp_ctrl.add_en = 1'b1;
               pick_in        = pend_idx_ff;
            end
            // Stop at the first hit; otherwise the last present entry stands.
            if (dp_stat.hit) begin
               pend_in  = 1'b0;
               state_in = wsp_pkg::ST_RESP;
            end else if (!issue && !pend_ff) begin
               state_in = wsp_pkg::ST_RESP;
            end
         end
         wsp_pkg::ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = wsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wsp_pkg::ST_IDLE;
         pend_ff    <= 1'b0;
         present_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pend_idx_ff <= pend_idx_in;
      mcnt_ff     <= mcnt_in;
      pick_ff     <= pick_in;
      empty_ff    <= empty_in;
   end

   assign pick_ext         = {{wsp_pkg::PICK_W{1'b0}}, pick_ff};
   assign req_ch.ready     = (state_ff == wsp_pkg::ST_IDLE);
   assign rsp_ch.valid     = (state_ff == wsp_pkg::ST_RESP);
   assign rsp_ch.picked    = pick_ext[wsp_pkg::PICK_W-1:0];
   assign rsp_ch.empty_res = empty_ff;

endmodule

// ===== rtl/wsp_ram.sv =====
// Weight table memory: one write port, one registered read port.
module wsp_ram #(
   parameter int unsigned DEPTH  = wsp_pkg::NUM_STRATA_DEF,
   parameter int unsigned ADDR_W = 5,
   parameter int unsigned DATA_W = wsp_pkg::WEIGHT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wsp_datapath.sv =====
// Shared adder datapath: weight sum, shift-add threshold product, running sum.
module wsp_datapath #(
   parameter int unsigned WEIGHT_WIDTH = wsp_pkg::WEIGHT_WIDTH_DEF,
   parameter int unsigned SUM_W        = wsp_pkg::WEIGHT_WIDTH_DEF + 6
) (
   input  logic                        clock,
   input  wsp_pkg::dp_ctrl_type        ctrl,
   input  logic [WEIGHT_WIDTH-1:0]     rd_data,
   input  logic [wsp_pkg::FRAC_W-1:0]  frac_load,
   output wsp_pkg::dp_stat_type        stat
);

   localparam int unsigned ADD_W = SUM_W + 1;

   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [SUM_W-1:0]           thr_ff, thr_in;
   logic [wsp_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [ADD_W-1:0]           op_a;
   logic [ADD_W-1:0]           op_b;
   logic [ADD_W-1:0]           add_res;

   // One adder serves every phase; the multiply step adds the sum into the
   // partial product when the current fraction bit is set.
   always_comb begin
      if (ctrl.op == wsp_pkg::DP_MUL) begin
         op_a = {1'b0, thr_ff};
         op_b = frac_ff[0] ? {1'b0, acc_ff} : '0;
      end else begin
         op_a = {1'b0, acc_ff};
         op_b = {{(ADD_W - WEIGHT_WIDTH){1'b0}}, rd_data};
      end
      add_res = op_a + op_b;
   end

   always_comb begin
      acc_in  = acc_ff;
      thr_in  = thr_ff;
      frac_in = frac_ff;
      unique case (ctrl.op)
         wsp_pkg::DP_START: begin
            acc_in  = '0;
            thr_in  = '0;
            frac_in = frac_load;
         end
         wsp_pkg::DP_ACC: begin
            if (ctrl.add_en) begin
               acc_in = add_res[SUM_W-1:0];
            end
         end
         wsp_pkg::DP_MUL: begin
            // Halve after each add; the nested floors give the exact product >> 16.
            thr_in  = add_res[SUM_W:1];
            frac_in = frac_ff >> 1;
         end
         wsp_pkg::DP_CLEAR: begin
            acc_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      thr_ff  <= thr_in;
      frac_ff <= frac_in;
   end

   assign stat.zero = (acc_ff == '0);
   assign stat.hit  = ctrl.add_en && (add_res > {1'b0, thr_ff});

endmodule
